[rtl/core/bps_pkg.sv]
// shared types and constants for the byte pattern search block
package bps_pkg;

	localparam int BYTE_W        = 8;
	localparam int PAT_IDX_W     = 9;
	localparam int PAT_LEN_W     = 9;
	localparam int HIT_LIMIT_W   = 7;
	localparam int HIT_COUNT_W   = 7;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam int DEF_PATTERN_DEPTH = 512;
	localparam int DEF_OFFSET_BITS   = 26;
	localparam int DEF_MAX_HITS      = 64;

	localparam logic [PAT_LEN_W-1:0]   PAT_LEN_RST   = 9'd3;
	localparam logic [HIT_LIMIT_W-1:0] HIT_LIMIT_RST = 7'd64;

	// register indexes, taken from paddr[2]
	localparam logic REG_PAT_LEN   = 1'b0;
	localparam logic REG_HIT_LIMIT = 1'b1;

	// input selector on s_tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_SCAN = 1'b1;

	// result kind on m_tuser
	localparam logic KIND_HIT     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// per-beat control broadcast to every cell
	typedef struct packed {
		logic              scan;
		logic              clear;
		logic [BYTE_W-1:0] value;
	} bps_cell_ctrl_t;

endpackage

[rtl/core/bps_cell.sv]
// one cell of the match chain: a pattern byte and its partial match bit
module bps_cell #(
	parameter bit HEAD = 1'b0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bps_pkg::bps_cell_ctrl_t ctrl,
	input  logic                    wr_en,
	input  logic                    prev,
	output logic                    match
);
	import bps_pkg::*;

	logic [BYTE_W-1:0] pat_q;
	logic              match_q;
	logic              chain_in;

	// the head cell always starts a new prefix, the others drop it on a region start
	assign chain_in = prev & (HEAD | ~ctrl.clear);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= ctrl.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.scan) begin
			match_q <= chain_in & (pat_q == ctrl.value);
		end
	end

	assign match = match_q;

endmodule

[rtl/core/byte_pattern_search.sv]
// top level of the byte pattern search: cell chain, hit tracking, result register
// path: cells and stage 1 register a scanned byte; the result register drives m_*
// throughput: one byte per cycle unless m_tready stalls; a byte with a hit and a summary
//   holds the input longer, since the single result register takes one result a cycle
// reset: partial matches, position and hit count clear at once, config takes its reset values;
//   pattern bytes are undefined until loaded, and no clearing pass is needed
module byte_pattern_search #(
	parameter int PATTERN_DEPTH = bps_pkg::DEF_PATTERN_DEPTH,
	parameter int OFFSET_BITS   = bps_pkg::DEF_OFFSET_BITS,
	parameter int MAX_HITS      = bps_pkg::DEF_MAX_HITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// stream in
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// byte_value [7:0], pattern_index [16:8], first_of_region [17], zero fill
	input  logic [23:0]                              s_tdata,
	// func
	input  logic                                     s_tuser,
	// last_of_region
	input  logic                                     s_tlast,
	// stream out
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// hit_offset, then hit_count, zero fill to whole bytes
	output logic [((OFFSET_BITS+bps_pkg::HIT_COUNT_W+7)/8)*8-1:0] m_tdata,
	// kind
	output logic                                     m_tuser,
	// last_result
	output logic                                     m_tlast,
	// config
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [bps_pkg::APB_ADDR_W-1:0]           paddr,
	input  logic [bps_pkg::APB_DATA_W-1:0]           pwdata,
	output logic [bps_pkg::APB_DATA_W-1:0]           prdata,
	output logic                                     pready
);
	import bps_pkg::*;

	localparam int IDX_W   = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int LW      = (IDX_W + 1 > PAT_LEN_W) ? IDX_W + 1 : PAT_LEN_W;
	localparam int CW      = $clog2(MAX_HITS + 1);
	localparam int CLW     = (CW > HIT_LIMIT_W) ? CW : HIT_LIMIT_W;
	localparam int DW      = (OFFSET_BITS > LW) ? OFFSET_BITS : LW;
	localparam int XW      = (IDX_W > PAT_IDX_W) ? IDX_W : PAT_IDX_W;
	localparam int TD_W    = ((OFFSET_BITS + HIT_COUNT_W + 7) / 8) * 8;
	localparam int PAD_W   = TD_W - OFFSET_BITS - HIT_COUNT_W;

	localparam logic [LW-1:0]  DEPTH_L = LW'(PATTERN_DEPTH);
	localparam logic [CLW-1:0] MAX_L   = CLW'(MAX_HITS);

	// configuration
	logic [PAT_LEN_W-1:0]   pat_len_q;
	logic [HIT_LIMIT_W-1:0] hit_limit_q;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q   <= PAT_LEN_RST;
			hit_limit_q <= HIT_LIMIT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_PAT_LEN:   pat_len_q   <= pwdata[PAT_LEN_W-1:0];
				REG_HIT_LIMIT: hit_limit_q <= pwdata[HIT_LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PAT_LEN:   prdata = APB_DATA_W'(pat_len_q);
			REG_HIT_LIMIT: prdata = APB_DATA_W'(hit_limit_q);
			default:       prdata = '0;
		endcase
	end

	// clamped config
	logic [LW-1:0]    len_raw, len_eff, len_m1;
	logic [IDX_W-1:0] sel_idx;
	logic [CLW-1:0]   limit_raw, limit_eff;

	always_comb begin
		len_raw = LW'(pat_len_q);
		if (len_raw == '0) begin
			len_eff = LW'(1);
		end else if (len_raw > DEPTH_L) begin
			len_eff = DEPTH_L;
		end else begin
			len_eff = len_raw;
		end
		len_m1    = len_eff - LW'(1);
		sel_idx   = len_m1[IDX_W-1:0];
		limit_raw = CLW'(hit_limit_q);
		limit_eff = (limit_raw > MAX_L) ? MAX_L : limit_raw;
	end

	// input decode
	logic                 in_acc;
	logic                 in_scan, in_load, in_first;
	logic [BYTE_W-1:0]    in_byte;
	logic [PAT_IDX_W-1:0] in_idx;
	logic [XW-1:0]        in_idx_x;

	assign in_acc   = s_tvalid & s_tready;
	assign in_byte  = s_tdata[BYTE_W-1:0];
	assign in_idx   = s_tdata[BYTE_W +: PAT_IDX_W];
	assign in_first = s_tdata[BYTE_W+PAT_IDX_W];
	assign in_scan  = in_acc & (s_tuser == FUNC_SCAN);
	assign in_load  = in_acc & (s_tuser == FUNC_LOAD);
	assign in_idx_x = XW'(in_idx);

	// cell chain
	bps_cell_ctrl_t           cell_ctrl;
	logic [PATTERN_DEPTH-1:0] pm;
	logic [PATTERN_DEPTH-1:0] wr_sel;

	assign cell_ctrl.scan  = in_scan;
	assign cell_ctrl.clear = in_first;
	assign cell_ctrl.value = in_byte;

	for (genvar k = 0; k < PATTERN_DEPTH; k++) begin : g_cell
		assign wr_sel[k] = in_load & (in_idx_x == XW'(k));
		if (k == 0) begin : g_head
			bps_cell #(.HEAD(1'b1)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (cell_ctrl),
				.wr_en  (wr_sel[k]),
				.prev   (1'b1),
				.match  (pm[k])
			);
		end else begin : g_body
			bps_cell #(.HEAD(1'b0)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (cell_ctrl),
				.wr_en  (wr_sel[k]),
				.prev   (pm[k-1]),
				.match  (pm[k])
			);
		end
	end

	// position tracking at the input beat
	logic [OFFSET_BITS-1:0] pos_q, pos_base;
	logic                   pos_ok;

	assign pos_base = in_first ? '0 : pos_q;
	assign pos_ok   = (pos_base != '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_scan) begin
			pos_q <= pos_ok ? pos_base + OFFSET_BITS'(1) : pos_base;
		end
	end

	// stage 1: the scanned byte waits here until its results are out
	logic                   v_s1;
	logic                   first_s1, last_s1, in_range_s1;
	logic [OFFSET_BITS-1:0] pos_s1;
	logic                   phase_q;
	logic [CW-1:0]          hits_q;

	always_ff @(posedge clk) begin
		if (in_scan) begin
			first_s1    <= in_first;
			last_s1     <= s_tlast;
			in_range_s1 <= pos_ok;
			pos_s1      <= pos_base;
		end
	end

	logic                   hit;
	logic [CW-1:0]          cnt_base, cnt_now;
	logic [DW-1:0]          off_wide;
	logic [OFFSET_BITS-1:0] hit_off;
	logic                   out_free, has_res, final_phase, s1_retire, emit;

	// pm is stable while the byte sits in stage 1, since no new scan is taken
	always_comb begin
		cnt_base = first_s1 ? '0 : hits_q;
		hit      = in_range_s1 & pm[sel_idx] & (CLW'(cnt_base) < limit_eff);
		cnt_now  = cnt_base + CW'(hit);
		off_wide = DW'(pos_s1) - DW'(len_m1);
		hit_off  = off_wide[OFFSET_BITS-1:0];
	end

	assign out_free    = ~m_tvalid | m_tready;
	assign has_res     = hit | last_s1;
	assign final_phase = phase_q | ~(hit & last_s1);
	assign emit        = v_s1 & has_res & out_free;
	assign s1_retire   = v_s1 & (~has_res | (out_free & final_phase));
	assign s_tready    = ~v_s1 | s1_retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			phase_q <= 1'b0;
			hits_q  <= '0;
		end else begin
			if (in_scan) begin
				v_s1 <= 1'b1;
			end else if (s1_retire) begin
				v_s1 <= 1'b0;
			end
			if (s1_retire) begin
				phase_q <= 1'b0;
				hits_q  <= cnt_now;
			end else if (emit) begin
				phase_q <= 1'b1;
			end
		end
	end

	// result register
	logic                   out_v_q;
	logic                   kind_q, last_res_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [HIT_COUNT_W-1:0] cnt_q;
	logic                   send_hit;

	assign send_hit = hit & ~phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q     <= send_hit ? KIND_HIT : KIND_SUMMARY;
			off_q      <= send_hit ? hit_off : '0;
			cnt_q      <= HIT_COUNT_W'(cnt_now);
			last_res_q <= send_hit ? ~last_s1 : 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_res_q;
	assign m_tdata  = {{PAD_W{1'b0}}, cnt_q, off_q};

endmodule

[tb/sv/tb_byte_pattern_search.sv]
// self-checking testbench for byte_pattern_search: stream stimulus, apb config, result checks
module tb_byte_pattern_search;
	timeunit 1ns;
	timeprecision 1ps;
	import bps_pkg::*;

	localparam int DEPTH        = DEF_PATTERN_DEPTH;
	localparam int OFF_W        = DEF_OFFSET_BITS;
	localparam int MDATA_W      = ((OFF_W + HIT_COUNT_W + 7) / 8) * 8;
	localparam int ITEMS_TARGET = 1650;
	localparam int HOLD_CYCLES  = 300;
	localparam int NUM_ROWS     = 24;

	typedef struct packed {
		logic                   kind;
		logic [OFF_W-1:0]       offset;
		logic [HIT_COUNT_W-1:0] count;
		logic                   last;
	} res_t;

	typedef struct packed {
		logic                 func;
		logic [BYTE_W-1:0]    value;
		logic [PAT_IDX_W-1:0] idx;
		logic                 is_first;
		logic                 is_last;
		logic                 has_typed;
		logic [1:0]           n_typed;
		res_t [1:0]           typed;
	} stim_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		stim_t          item;
		logic           reg_sel;
		logic [8:0]     reg_val;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;
	logic                  s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [MDATA_W-1:0]    m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	byte_pattern_search u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// predictor state
	logic [BYTE_W-1:0]      pat_mem [DEPTH];
	logic [DEPTH-1:0]       match_vec;
	logic [OFF_W-1:0]       byte_pos;
	logic [HIT_COUNT_W-1:0] hits_now;
	logic [PAT_LEN_W-1:0]   cfg_len;
	logic [HIT_LIMIT_W-1:0] cfg_limit;
	res_t                   pending_results [$];

	// stimulus side
	logic [BYTE_W-1:0] pat_plan [DEPTH];
	stim_t             cur_item;
	row_t              dir_rows [NUM_ROWS];
	int                beats_sent;
	int                mismatches;
	logic              tx_idle;
	logic              rx_idle;
	logic              long_hold;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("tb_byte_pattern_search failed");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	function automatic void queue_result(input res_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void search_step(input stim_t it, output res_t [1:0] outs, output int n);
		int len_eff;
		int lim_eff;
		logic [OFF_W-1:0] at;
		logic in_rng;
		n = 0;
		outs = '0;
		if (it.func == FUNC_LOAD) begin
			pat_mem[it.idx] = it.value;
			return;
		end
		if (it.is_first) begin
			match_vec = '0;
			byte_pos  = '0;
			hits_now  = '0;
		end
		len_eff = (cfg_len == 0) ? 1 : int'(cfg_len);
		lim_eff = (cfg_limit > DEF_MAX_HITS) ? DEF_MAX_HITS : int'(cfg_limit);
		// shift-and: prefix k+1 matches if prefix k matched one byte earlier
		for (int k = DEPTH - 1; k > 0; k--)
			match_vec[k] = match_vec[k-1] && (pat_mem[k] == it.value);
		match_vec[0] = (pat_mem[0] == it.value);
		at = byte_pos;
		in_rng = (at != '1);
		if (in_rng)
			byte_pos = at + 1'b1;
		if (in_rng && match_vec[len_eff-1] && hits_now < lim_eff) begin
			hits_now = hits_now + 1'b1;
			outs[n].kind   = KIND_HIT;
			outs[n].offset = at - OFF_W'(len_eff - 1);
			outs[n].count  = hits_now;
			outs[n].last   = !it.is_last;
			n++;
		end
		if (it.is_last) begin
			outs[n].kind   = KIND_SUMMARY;
			outs[n].offset = '0;
			outs[n].count  = hits_now;
			outs[n].last   = 1'b1;
			n++;
		end
	endfunction

	always @(posedge clk) begin : take_in
		res_t [1:0] outs;
		int n;
		if (arst_n && s_tvalid && s_tready) begin
			search_step(cur_item, outs, n);
			if (cur_item.has_typed) begin
				for (int i = 0; i < cur_item.n_typed; i++)
					queue_result(cur_item.typed[i]);
			end else begin
				for (int i = 0; i < n; i++)
					queue_result(outs[i]);
			end
		end
	end

	always @(posedge clk) begin : check_out
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind   = m_tuser;
			got.offset = m_tdata[OFF_W-1:0];
			got.count  = m_tdata[OFF_W +: HIT_COUNT_W];
			got.last   = m_tlast;
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected beat: kind=%0d offset=%0d count=%0d last=%0d",
					got.kind, got.offset, got.count, got.last));
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					note_mismatch($sformatf({"result mismatch: expected kind=%0d offset=%0d ",
						"count=%0d last=%0d, got kind=%0d offset=%0d count=%0d last=%0d"},
						want.kind, want.offset, want.count, want.last,
						got.kind, got.offset, got.count, got.last));
			end
		end
	end

	// result side: random stall per beat, one long hold on request
	initial begin : rx_side
		int stall;
		forever begin
			@(negedge clk);
			stall = rx_idle ? $urandom_range(0, 17) : 0;
			if (long_hold) begin
				stall = HOLD_CYCLES;
				long_hold = 1'b0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_tvalid));
		end
	end

	function automatic stim_t mk_item(input logic func, input logic [7:0] v,
			input logic [8:0] idx, input logic fi, input logic la);
		stim_t it;
		it = '0;
		it.func     = func;
		it.value    = v;
		it.idx      = idx;
		it.is_first = fi;
		it.is_last  = la;
		return it;
	endfunction

	function automatic res_t hit_res(input int off, input int cnt, input logic la);
		res_t r;
		r.kind   = KIND_HIT;
		r.offset = OFF_W'(off);
		r.count  = HIT_COUNT_W'(cnt);
		r.last   = la;
		return r;
	endfunction

	function automatic res_t sum_res(input int cnt);
		res_t r;
		r.kind   = KIND_SUMMARY;
		r.offset = '0;
		r.count  = HIT_COUNT_W'(cnt);
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic row_t ld(input logic [8:0] idx, input logic [7:0] v, input logic fl);
		row_t rw;
		rw = '0;
		rw.kind = ROW_ITEM;
		rw.item = mk_item(FUNC_LOAD, v, idx, fl, fl);
		rw.item.has_typed = 1'b1;
		return rw;
	endfunction

	function automatic row_t sc(input logic [7:0] v, input logic fi, input logic la,
			input int n = 0, input res_t r0 = '0, input res_t r1 = '0);
		row_t rw;
		rw = '0;
		rw.kind = ROW_ITEM;
		rw.item = mk_item(FUNC_SCAN, v, '0, fi, la);
		rw.item.has_typed = 1'b1;
		rw.item.n_typed   = 2'(n);
		rw.item.typed[0]  = r0;
		rw.item.typed[1]  = r1;
		return rw;
	endfunction

	function automatic row_t cf(input logic reg_sel, input logic [8:0] val);
		row_t rw;
		rw = '0;
		rw.kind    = ROW_CFG;
		rw.reg_sel = reg_sel;
		rw.reg_val = val;
		return rw;
	endfunction

	task automatic send(input stim_t it);
		int gap;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_item = it;
		if (it.func == FUNC_LOAD)
			pat_plan[it.idx] = it.value;
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, it.is_first, it.idx, it.value};
		s_tuser  <= it.func;
		s_tlast  <= it.is_last;
		beats_sent++;
		do @(posedge clk); while (!s_tready);
	endtask

	// loads and missed scans give no beat, so allow the pipeline to drain past the last result
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic reg_sel, input logic [31:0] wd,
			output logic [31:0] rd);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= wd;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if (wr) begin
			if (reg_sel == REG_PAT_LEN)
				cfg_len = wd[PAT_LEN_W-1:0];
			else
				cfg_limit = wd[HIT_LIMIT_W-1:0];
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_reg(input logic reg_sel, input logic [31:0] want);
		logic [31:0] rd;
		apb_access(1'b0, reg_sel, '0, rd);
		if (rd !== want)
			note_mismatch($sformatf("register %0d readback: expected %0d, got %0d",
				reg_sel, want, rd));
	endtask

	task automatic cfg_write(input logic reg_sel, input logic [8:0] val);
		logic [31:0] wd;
		logic [31:0] rd;
		logic [31:0] mask;
		wait_idle();
		// junk in the upper bits must be dropped by the register
		wd = ($urandom & ~32'h1FF) | 32'(val);
		mask = (reg_sel == REG_PAT_LEN) ? 32'h1FF : 32'h7F;
		apb_access(1'b1, reg_sel, wd, rd);
		check_reg(reg_sel, wd & mask);
	endtask

	function automatic logic [7:0] filler_byte(input int len_eff, input logic two_sym,
			input logic [7:0] sym_a, input logic [7:0] sym_b);
		if (two_sym)
			return ($urandom_range(0, 7) == 0) ? 8'($urandom) :
				($urandom_range(0, 1) ? sym_a : sym_b);
		return $urandom_range(0, 1) ? pat_plan[$urandom_range(0, len_eff - 1)] : 8'($urandom);
	endfunction

	// a region is mostly pattern copies, some with one byte spoiled, between filler bytes
	task automatic gen_region(input int len_eff, input logic two_sym, input logic [7:0] sym_a,
			input logic [7:0] sym_b, input logic long_one);
		logic [7:0] bq [$];
		int goal;
		int r;
		int cut;
		int n;
		logic fresh;
		logic fi;
		logic la;
		if (long_one) begin
			repeat (2) bq = {bq, filler_byte(len_eff, two_sym, sym_a, sym_b)};
			for (int j = 0; j < len_eff; j++)
				bq = {bq, pat_plan[j]};
			bq = {bq, filler_byte(len_eff, two_sym, sym_a, sym_b)};
		end else begin
			goal = $urandom_range(6, 40);
			while (bq.size() < goal) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					cut = (r < 55) ? -1 : $urandom_range(0, len_eff - 1);
					for (int j = 0; j < len_eff; j++)
						bq = {bq, ((j == cut) ? ~pat_plan[j] : pat_plan[j])};
				end else begin
					n = $urandom_range(1, 3);
					repeat (n) bq = {bq, filler_byte(len_eff, two_sym, sym_a, sym_b)};
				end
			end
		end
		fresh = ($urandom_range(0, 7) != 0);
		for (int i = 0; i < bq.size(); i++) begin
			if (!long_one && $urandom_range(0, 24) == 0)
				send(mk_item(FUNC_LOAD, 8'($urandom), 9'($urandom), 1'($urandom),
					1'($urandom)));
			fi = fresh && (i == 0);
			la = (i == bq.size() - 1) || ($urandom_range(0, 31) == 0);
			send(mk_item(FUNC_SCAN, bq[i], 9'($urandom), fi, la));
		end
	endtask

	task automatic run_phase(input int ph);
		logic [8:0] plen;
		logic [6:0] plim;
		int len_eff;
		int nreg;
		int r;
		logic two_sym;
		logic [7:0] sym_a;
		logic [7:0] sym_b;
		if (ph == 0) begin
			plen = 9'd511;
			plim = 7'd64;
		end else if (ph == 1) begin
			plen = 9'd1;
			plim = 7'd64;
		end else begin
			r = $urandom_range(0, 9);
			if (r < 5)
				plen = 9'($urandom_range(1, 4));
			else if (r < 8)
				plen = 9'($urandom_range(5, 12));
			else if (r == 8)
				plen = 9'd0;
			else
				plen = 9'($urandom_range(13, 40));
			r = $urandom_range(0, 9);
			if (r == 0)
				plim = 7'd0;
			else if (r < 3)
				plim = 7'd1;
			else if (r == 3)
				plim = 7'd64;
			else if (r == 4)
				plim = 7'd127;
			else
				plim = 7'($urandom_range(2, 8));
		end
		cfg_write(REG_PAT_LEN, plen);
		cfg_write(REG_HIT_LIMIT, {2'b00, plim});
		len_eff = (plen == 0) ? 1 : int'(plen);
		tx_idle = (ph != 1) && ($urandom_range(0, 3) != 0);
		rx_idle = ($urandom_range(0, 3) != 0);
		two_sym = 1'b0;
		sym_a = 8'($urandom);
		sym_b = 8'($urandom);
		// a two-symbol pattern makes overlapping matches common
		if (ph == 1 || (len_eff <= 16 && $urandom_range(0, 1) == 1)) begin
			two_sym = 1'b1;
			for (int i = 0; i < len_eff; i++)
				send(mk_item(FUNC_LOAD, $urandom_range(0, 1) ? sym_a : sym_b, 9'(i), 1'b0, 1'b0));
		end
		if (ph == 1)
			long_hold = 1'b1;
		nreg = (ph == 0) ? 1 : $urandom_range(3, 6);
		repeat (nreg) gen_region(len_eff, two_sym, sym_a, sym_b, ph == 0);
	endtask

	initial begin : stimulus
		int ph;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		long_hold = 1'b0;
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		beats_sent = 0;
		mismatches = 0;
		cur_item  = '0;
		match_vec = '0;
		byte_pos  = '0;
		hits_now  = '0;
		cfg_len   = PAT_LEN_RST;
		cfg_limit = HIT_LIMIT_RST;
		for (int i = 0; i < DEPTH; i++) begin
			pat_mem[i]  = '0;
			pat_plan[i] = '0;
		end

		dir_rows = '{
			ld(9'd0, 8'h00, 1'b1),
			ld(9'd1, 8'hFF, 1'b0),
			ld(9'd2, 8'h00, 1'b1),
			ld(9'h1FF, 8'hFF, 1'b0),
			sc(8'h00, 1'b1, 1'b0),
			sc(8'hFF, 1'b0, 1'b0),
			sc(8'h00, 1'b0, 1'b0, 1, hit_res(0, 1, 1'b1)),
			sc(8'hFF, 1'b0, 1'b0),
			// overlapping match
			sc(8'h00, 1'b0, 1'b0, 1, hit_res(2, 2, 1'b1)),
			sc(8'h55, 1'b0, 1'b1, 1, sum_res(2)),
			// region goes on after its summary
			sc(8'hFF, 1'b0, 1'b0),
			sc(8'h00, 1'b0, 1'b0),
			sc(8'hFF, 1'b0, 1'b0),
			sc(8'h00, 1'b0, 1'b1, 2, hit_res(7, 3, 1'b0), sum_res(3)),
			sc(8'h00, 1'b1, 1'b1, 1, sum_res(0)),
			cf(REG_HIT_LIMIT, 9'd0),
			sc(8'h00, 1'b1, 1'b0),
			sc(8'hFF, 1'b0, 1'b0),
			sc(8'h00, 1'b0, 1'b1, 1, sum_res(0)),
			// zero length acts as one, limit above max is clamped
			cf(REG_PAT_LEN, 9'd0),
			cf(REG_HIT_LIMIT, 9'd127),
			sc(8'h00, 1'b1, 1'b1, 2, hit_res(0, 1, 1'b0), sum_res(1)),
			sc(8'hAB, 1'b0, 1'b0),
			sc(8'h00, 1'b0, 1'b1, 2, hit_res(2, 2, 1'b0), sum_res(2))
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_reg(REG_PAT_LEN, 32'(PAT_LEN_RST));
		check_reg(REG_HIT_LIMIT, 32'(HIT_LIMIT_RST));

		// every scan compares all cells, so the whole store is written first
		for (int i = 0; i < DEPTH; i++)
			send(mk_item(FUNC_LOAD, 8'($urandom), 9'(i), 1'($urandom), 1'($urandom)));

		for (int i = 0; i < NUM_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_CFG)
				cfg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
			else
				send(dir_rows[i].item);
		end

		ph = 0;
		while (beats_sent < ITEMS_TARGET) begin
			run_phase(ph);
			ph++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_byte_pattern_search passed");
		else
			$display("tb_byte_pattern_search failed");
		$finish;
	end

endmodule
